### hw/rtl/gap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_pkg: shared types and constants of the gcd and primality unit
// Item structs, queue command, divider request/response and back-end states.
// ----------------------------------------------------------------------------
package gap_pkg;

    // Operand width used for arithmetic; fields are sized by FIELD_W.
    localparam int DATA_WIDTH  = 32;
    localparam int FIELD_W     = 32;
    localparam int EXT_W       = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int GCD_W       = 31;
    localparam int CNT_W       = $clog2(DATA_WIDTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_WIDTH-1:0] FIRST_DIVISOR = DATA_WIDTH'(2);

    typedef struct packed {
        logic                      mode;
        logic signed [FIELD_W-1:0] first_operand;
        logic signed [FIELD_W-1:0] second_operand;
    } t_in_item;

    typedef struct packed {
        logic [GCD_W-1:0] gcd_value;
        logic             operand_error;
        logic             is_prime;
    } t_out_item;

    // Mode codes of the input item
    localparam logic MODE_GCD   = 1'b0;
    localparam logic MODE_PRIME = 1'b1;

    typedef enum logic [2:0] {
        CMD_FIXED = 3'b001,
        CMD_GCD   = 3'b010,
        CMD_PRIME = 3'b100
    } t_cmd_kind;

    // opa: dividend (larger gcd operand or tested value), opb: first divisor
    typedef struct packed {
        t_cmd_kind             kind;
        logic [DATA_WIDTH-1:0] opa;
        logic [DATA_WIDTH-1:0] opb;
        t_out_item             fixed_res;
    } t_cmd;

    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] rem;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_back_state;

endpackage

### hw/rtl/gap_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_front: input acceptance and classification
// Checks operand signs, orders gcd operands and resolves trivial items into
// a ready-made result before they enter the command queue.
// ----------------------------------------------------------------------------
module gap_front (
    input  gap_pkg::t_in_item i_in_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_full,
    output logic              o_push,
    output gap_pkg::t_cmd     o_cmd
);

    logic [gap_pkg::EXT_W-1:0]      ext_a;
    logic [gap_pkg::EXT_W-1:0]      ext_b;
    logic [gap_pkg::DATA_WIDTH-1:0] op_a;
    logic [gap_pkg::DATA_WIDTH-1:0] op_b;
    logic                           pos_a;
    logic                           pos_b;

    // Sign-extend, then keep the operand width
    assign ext_a = gap_pkg::EXT_W'(i_in_data.first_operand);
    assign ext_b = gap_pkg::EXT_W'(i_in_data.second_operand);
    assign op_a  = ext_a[gap_pkg::DATA_WIDTH-1:0];
    assign op_b  = ext_b[gap_pkg::DATA_WIDTH-1:0];
    assign pos_a = !op_a[gap_pkg::DATA_WIDTH-1] && (op_a != '0);
    assign pos_b = !op_b[gap_pkg::DATA_WIDTH-1] && (op_b != '0);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_cmd           = '0;
        o_cmd.kind      = gap_pkg::CMD_FIXED;
        if (i_in_data.mode == gap_pkg::MODE_GCD) begin
            if (pos_a && pos_b) begin
                o_cmd.kind = gap_pkg::CMD_GCD;
                o_cmd.opa  = (op_a < op_b) ? op_b : op_a;
                o_cmd.opb  = (op_a < op_b) ? op_a : op_b;
            end else begin
                o_cmd.fixed_res.operand_error = 1'b1;
            end
        end else begin
            // values below two are never prime; the result stays all zero
            if (!op_a[gap_pkg::DATA_WIDTH-1] && (op_a >= gap_pkg::FIRST_DIVISOR)) begin
                o_cmd.kind = gap_pkg::CMD_PRIME;
                o_cmd.opa  = op_a;
                o_cmd.opb  = gap_pkg::FIRST_DIVISOR;
            end
        end
    end

endmodule

### hw/rtl/gap_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_fifo: command queue between front and back end
// Small register queue; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module gap_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gap_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output gap_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);

    gap_pkg::t_cmd               r_mem [gap_pkg::QUEUE_DEPTH];
    logic [gap_pkg::QPTR_W-1:0]  r_wptr;
    logic [gap_pkg::QPTR_W-1:0]  r_rptr;
    logic [gap_pkg::QCNT_W-1:0]  r_count;
    logic [gap_pkg::QPTR_W-1:0]  n_wptr;
    logic [gap_pkg::QPTR_W-1:0]  n_rptr;
    logic [gap_pkg::QCNT_W-1:0]  n_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == gap_pkg::QCNT_W'(gap_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == gap_pkg::QPTR_W'(gap_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == gap_pkg::QPTR_W'(gap_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gap_pkg::QCNT_W'(gap_pkg::QUEUE_DEPTH))
        else $error("command queue count past depth");

endmodule

### hw/rtl/gap_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_div: shared modulo engine
// Restoring radix-2 divider, one quotient bit per cycle; returns quotient
// and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module gap_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gap_pkg::t_div_req i_req,
    output gap_pkg::t_div_rsp o_rsp
);

    localparam int DW = gap_pkg::DATA_WIDTH;

    logic                        r_busy;
    logic                        r_done;
    logic [gap_pkg::CNT_W-1:0]   r_cnt;
    logic [DW-1:0]               r_rem;
    logic [DW-1:0]               r_quo;
    logic [DW-1:0]               r_dvs;
    logic [DW:0]                 trial;
    logic [DW-1:0]               n_rem;
    logic [DW-1:0]               n_quo;

    assign trial = {r_rem, r_quo[DW-1]} - {1'b0, r_dvs};

    always_comb begin
        if (!trial[DW]) begin
            n_rem = trial[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            // restore: keep the shifted partial remainder
            n_rem = {r_rem[DW-2:0], r_quo[DW-1]};
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == gap_pkg::CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_cnt <= gap_pkg::CNT_W'(DW);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy && !r_done)
        else $error("divider started while still working");

endmodule

### hw/rtl/gap_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_back: execution sequencer and output register
// Runs Euclid's remainder loop or trial division on the shared divider and
// holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module gap_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  gap_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output gap_pkg::t_div_req   o_div_req,
    input  gap_pkg::t_div_rsp   i_div_rsp,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gap_pkg::t_out_item  o_out_data
);

    localparam int DW = gap_pkg::DATA_WIDTH;

    gap_pkg::t_back_state r_state;
    gap_pkg::t_back_state n_state;
    gap_pkg::t_cmd_kind   r_kind;
    gap_pkg::t_cmd_kind   n_kind;
    logic [DW-1:0]        r_x;
    logic [DW-1:0]        n_x;
    logic [DW-1:0]        r_y;
    logic [DW-1:0]        n_y;
    logic                 r_start;
    logic                 n_start;
    gap_pkg::t_out_item   r_res;
    gap_pkg::t_out_item   n_res;
    logic                 r_out_valid;
    logic                 n_out_valid;
    gap_pkg::t_out_item   r_out_data;
    gap_pkg::t_out_item   n_out_data;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_x         = r_x;
        n_y         = r_y;
        n_start     = 1'b0;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            gap_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_kind = i_cmd.kind;
                    n_x    = i_cmd.opa;
                    n_y    = i_cmd.opb;
                    n_res  = i_cmd.fixed_res;
                    if (i_cmd.kind == gap_pkg::CMD_FIXED) begin
                        n_state = gap_pkg::S_DONE;
                    end else begin
                        n_start = 1'b1;
                        n_state = gap_pkg::S_DIV;
                    end
                end
            end
            gap_pkg::S_DIV: begin
                if (i_div_rsp.done) begin
                    n_res = '0;
                    if (r_kind == gap_pkg::CMD_GCD) begin
                        if (i_div_rsp.rem == '0) begin
                            n_res.gcd_value = gap_pkg::GCD_W'(r_y);
                            n_state         = gap_pkg::S_DONE;
                        end else begin
                            // advance: divisor becomes dividend, remainder the divisor
                            n_x     = r_y;
                            n_y     = i_div_rsp.rem;
                            n_start = 1'b1;
                        end
                    end else begin
                        if (r_y > i_div_rsp.quo) begin
                            n_res.is_prime = 1'b1;
                            n_state        = gap_pkg::S_DONE;
                        end else if (i_div_rsp.rem == '0) begin
                            n_state = gap_pkg::S_DONE;
                        end else begin
                            n_y     = r_y + DW'(1);
                            n_start = 1'b1;
                        end
                    end
                end
            end
            gap_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = gap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gap_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gap_pkg::S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_x        <= n_x;
        r_y        <= n_y;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_div_req.start    = r_start;
    assign o_div_req.dividend = r_x;
    assign o_div_req.divisor  = r_y;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == gap_pkg::S_DIV))
        else $error("divider start outside the divide state");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == gap_pkg::S_DIV))
        else $error("divider result with no operation waiting");

    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data.is_prime &&
                          (r_out_data.operand_error || (r_out_data.gcd_value != '0))))
        else $error("prime flag together with gcd fields");

endmodule

### hw/rtl/gcd_and_primality_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_and_primality_unit: gcd and trial-division primality on one divider
// Front end classifies items into a two-entry command queue; back end runs
// the remainder loops and presents one result per item.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_data  (mode, operands)
//  output  | o_out_valid | i_out_ready | o_out_data (gcd, error, prime)
//
//  Each division runs in the shared bit-serial divider.
//  Primality of v: up to floor(sqrt(v)) divisions; gcd error items and
//  values below two need no division.
//  Reset (synchronous, low) empties the queue and the output register.
//  Input stalls only when the queue is full; output stalls hold the result.
// ----------------------------------------------------------------------------
module gcd_and_primality_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gap_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gap_pkg::t_out_item o_out_data
);

    gap_pkg::t_cmd     push_cmd;
    gap_pkg::t_cmd     head_cmd;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    gap_pkg::t_div_req div_req;
    gap_pkg::t_div_rsp div_rsp;

    gap_front u_front (
        .i_in_data  (i_in_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_full     (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    gap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    gap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
